// ----- rtl/cpprof_pkg.sv -----
// Shared types, codes and saturating helpers for the call-path profiler.
package cpprof_pkg;

  typedef enum logic [2:0] {
    MODE_ENTER     = 3'd0,
    MODE_EXIT      = 3'd1,
    MODE_FOREIGN   = 3'd2,
    MODE_READ_PATH = 3'd3,
    MODE_READ_FUNC = 3'd4
  } mode_t;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_DISABLED = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  localparam logic [31:0] HASH_MUL_A = 32'h9e3779b9;
  localparam logic [31:0] HASH_MUL_B = 32'h85ebca6b;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_TOP, S_HASH, S_PROBE, S_CHECK, S_POP2, S_PUSH,
    S_FN_RD, S_FN_WR, S_PE_RD, S_PE_WR, S_DONE
  } fsm_t;

  typedef struct packed {
    logic [31:0] calls;
    logic [47:0] total;
    logic [47:0] self_tot;
  } pstat_t;

  typedef struct packed {
    logic [31:0] calls;
    logic [47:0] total;
    logic [47:0] self_tot;
    logic [31:0] min_t;
    logic [31:0] max_t;
  } fstat_t;

  typedef struct packed {
    logic        upd;
    logic [31:0] el;
    logic [31:0] self_t;
  } stat_upd_t;

  function automatic logic [47:0] sat48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  function automatic logic [31:0] inc32(input logic [31:0] a);
    return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
  endfunction

endpackage

// ----- rtl/cpprof_path_tab.sv -----
// Hash slot memory and call-path entry memory with path statistics update.
module cpprof_path_tab import cpprof_pkg::*; #(
  parameter int PATH_ENTRIES = 256,
  parameter int HASH_SLOTS   = 512,
  localparam int PE_W = $clog2(PATH_ENTRIES),
  localparam int PC_W = $clog2(PATH_ENTRIES + 1),
  localparam int PI_W = PE_W + 1,
  localparam int SL_W = $clog2(HASH_SLOTS)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  output logic                   busy,
  input  logic                   slot_re,
  input  logic [SL_W-1:0]        slot_ra,
  output logic [PC_W-1:0]        slot_q_v,
  output logic signed [PI_W-1:0] slot_q_par,
  output logic [7:0]             slot_q_fn,
  input  logic                   slot_we,
  input  logic [SL_W-1:0]        slot_wa,
  input  logic [PC_W-1:0]        slot_wv,
  input  logic signed [PI_W-1:0] slot_wpar,
  input  logic [7:0]             slot_wfn,
  input  logic                   pe_re,
  input  logic [PE_W-1:0]        pe_ra,
  output logic signed [PI_W-1:0] pe_q_par,
  output logic [7:0]             pe_q_fn,
  output pstat_t                 pe_q_stat,
  input  logic                   pe_create,
  input  stat_upd_t              pe_upd,
  input  logic [PE_W-1:0]        pe_wa,
  input  logic signed [PI_W-1:0] pe_wpar,
  input  logic [7:0]             pe_wfn
);

  localparam int SLOT_W = PC_W + PI_W + 8;
  localparam int ENT_W  = PI_W + 8 + $bits(pstat_t);

  logic [SLOT_W-1:0] slot_mem [HASH_SLOTS];
  logic [ENT_W-1:0]  pe_mem [PATH_ENTRIES];
  logic [SLOT_W-1:0] slot_q_r;
  logic [ENT_W-1:0]  pe_q_r;
  logic              busy_r;
  logic [SL_W-1:0]   clr_r;
  pstat_t            new_stat;
  logic              slot_we_m;
  logic [SL_W-1:0]   slot_wa_m;
  logic [SLOT_W-1:0] slot_wd_m;
  logic [ENT_W-1:0]  pe_wd;

  assign busy = busy_r;
  assign {slot_q_v, slot_q_par, slot_q_fn} = slot_q_r;
  assign {pe_q_par, pe_q_fn, pe_q_stat} = pe_q_r;

  // Sweep the slot table to empty after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
    end else if (busy_r) begin
      clr_r <= clr_r + SL_W'(1);
      if (clr_r == SL_W'(HASH_SLOTS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    slot_we_m = busy_r | slot_we;
    slot_wa_m = busy_r ? clr_r : slot_wa;
    slot_wd_m = busy_r ? '0 : {slot_wv, slot_wpar, slot_wfn};
  end

  always_comb begin
    new_stat.calls    = inc32(pe_q_stat.calls);
    new_stat.total    = sat48(pe_q_stat.total, pe_upd.el);
    new_stat.self_tot = sat48(pe_q_stat.self_tot, pe_upd.self_t);
    pe_wd = pe_create ? {pe_wpar, pe_wfn, {$bits(pstat_t){1'b0}}}
                      : {pe_q_par, pe_q_fn, new_stat};
  end

  always_ff @(posedge clk) begin
    if (slot_we_m) begin
      slot_mem[slot_wa_m] <= slot_wd_m;
    end
    if (slot_re) begin
      slot_q_r <= slot_mem[slot_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (pe_create || pe_upd.upd) begin
      pe_mem[pe_wa] <= pe_wd;
    end
    if (pe_re) begin
      pe_q_r <= pe_mem[pe_ra];
    end
  end

endmodule

// ----- rtl/cpprof_func_tab.sv -----
// Per-function statistics memory with its read-modify-write update.
module cpprof_func_tab import cpprof_pkg::*; #(
  parameter int FUNCTIONS = 256,
  localparam int FN_W = $clog2(FUNCTIONS)
) (
  input  logic            clk,
  input  logic            rst_n,
  output logic            busy,
  input  logic            rd_en,
  input  logic [FN_W-1:0] rd_addr,
  output fstat_t          rd_q,
  input  stat_upd_t       upd,
  input  logic [FN_W-1:0] upd_addr
);

  fstat_t          mem [FUNCTIONS];
  fstat_t          rd_q_r;
  fstat_t          new_q;
  logic            busy_r;
  logic [FN_W-1:0] clr_r;
  logic            we;
  logic [FN_W-1:0] wa;
  fstat_t          wd;

  assign busy = busy_r;
  assign rd_q = rd_q_r;

  // Sweep all statistics to zero after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
    end else if (busy_r) begin
      clr_r <= clr_r + FN_W'(1);
      if (clr_r == FN_W'(FUNCTIONS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    new_q          = rd_q_r;
    new_q.calls    = inc32(rd_q_r.calls);
    new_q.total    = sat48(rd_q_r.total, upd.el);
    new_q.self_tot = sat48(rd_q_r.self_tot, upd.self_t);
    if (rd_q_r.calls == 32'd0) begin
      new_q.min_t = upd.el;
      new_q.max_t = upd.el;
    end else begin
      if (upd.el < rd_q_r.min_t) new_q.min_t = upd.el;
      if (upd.el > rd_q_r.max_t) new_q.max_t = upd.el;
    end
    we = busy_r | upd.upd;
    wa = busy_r ? clr_r : upd_addr;
    wd = busy_r ? '0 : new_q;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/call_path_profiler_unit.sv -----
// Call-path profiler top level: scope stack, probe sequencer and result register.
//
// Each accepted word runs through a sequencer that owns three synchronous
// memories: the open-scope stack, the path table (hash slots plus path
// entries) and the per-function statistics. Every probe of the linear-probed
// slot table is one memory read and one compare. One word is in flight at a
// time; the next is accepted as soon as the previous result sits in the output
// register, even while the sink stalls it. After reset the block sweeps the
// slot table and the function table to zero with in_stall high; the enable
// register may be written during that time. Self time is elapsed minus the
// summed elapsed time of direct children, clamped at zero; totals saturate at
// 48 bits and counts at 32 bits. When the path table is full a path is dropped
// and the result reports table full with path index -1.
module call_path_profiler_unit import cpprof_pkg::*; #(
  parameter int PATH_ENTRIES = 256,
  parameter int HASH_SLOTS   = 512,
  parameter int STACK_DEPTH  = 32,
  parameter int FUNCTIONS    = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic [7:0]         in_func_id,
  input  logic [31:0]        in_elapsed_ticks,
  input  logic [7:0]         in_read_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [8:0]  out_path_index,
  output logic signed [8:0]  out_parent_index,
  output logic [7:0]         out_func_out,
  output logic [31:0]        out_self_ticks,
  output logic [31:0]        out_call_count,
  output logic [47:0]        out_total_ticks,
  output logic [47:0]        out_self_total_ticks,
  output logic [31:0]        out_min_ticks,
  output logic [31:0]        out_max_ticks,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_enabled
);

  localparam int PE_W = $clog2(PATH_ENTRIES);
  localparam int PC_W = $clog2(PATH_ENTRIES + 1);
  localparam int PI_W = PE_W + 1;
  localparam int SL_W = $clog2(HASH_SLOTS);
  localparam int SD_W = $clog2(STACK_DEPTH);
  localparam int DP_W = $clog2(STACK_DEPTH + 1);
  localparam int FN_W = $clog2(FUNCTIONS);

  // Open-scope stack, one row per open scope.
  logic signed [PI_W-1:0] stk_path_mem  [STACK_DEPTH];
  logic [7:0]             stk_func_mem  [STACK_DEPTH];
  logic [47:0]            stk_child_mem [STACK_DEPTH];
  logic signed [PI_W-1:0] stk_q_path;
  logic [7:0]             stk_q_func;
  logic [47:0]            stk_q_child;
  logic                   stk_re, stk_we;
  logic [SD_W-1:0]        stk_ra, stk_wa;
  logic signed [PI_W-1:0] stk_wpath;
  logic [7:0]             stk_wfunc;
  logic [47:0]            stk_wchild;

  fsm_t state_r, state_nxt;

  // Control state.
  logic                   enabled_r;
  logic [DP_W-1:0]        depth_r;
  logic [PC_W-1:0]        pc_r;
  logic [31:0]            ovf_r, drop_r;
  logic                   out_valid_r;

  // Item and working registers.
  mode_t                  mode_r;
  logic [7:0]             fid_r, ridx_r, fn_r;
  logic [31:0]            el_r;
  logic signed [PI_W-1:0] key_par_r, pi_r, par_r;
  logic [SL_W-1:0]        slot_r;
  logic [SL_W-1:0]        n_r;
  logic [1:0]             status_r;
  logic [7:0]             fo_r;
  logic [31:0]            self_r, calls_r, min_r, max_r;
  logic [47:0]            tot_r, stot_r;

  // Output register.
  logic [1:0]             o_status_r;
  logic signed [8:0]      o_pi_r, o_par_r;
  logic [7:0]             o_fo_r;
  logic [31:0]            o_self_r, o_calls_r, o_min_r, o_max_r;
  logic [47:0]            o_tot_r, o_stot_r;

  // Table ports.
  logic                   pt_busy, ft_busy;
  logic                   slot_re, slot_we;
  logic [SL_W-1:0]        slot_ra;
  logic [PC_W-1:0]        slot_q_v;
  logic signed [PI_W-1:0] slot_q_par;
  logic [7:0]             slot_q_fn;
  logic                   pe_re, pe_create;
  logic [PE_W-1:0]        pe_ra, pe_wa;
  logic signed [PI_W-1:0] pe_q_par;
  logic [7:0]             pe_q_fn;
  pstat_t                 pe_q_stat;
  stat_upd_t              pe_upd, fn_upd;
  logic                   fn_re;
  logic [FN_W-1:0]        fn_ra;
  fstat_t                 fn_q;

  // Decode helpers.
  logic                   accept, can_load;
  logic [DP_W-1:0]        dm1, dm2;
  logic [47:0]            child_sum;
  logic signed [PI_W-1:0] up_path;
  logic [31:0]            hash_p, hash_f, hash_h;
  logic                   slot_empty, slot_hit, pe_full, last_probe, lookup_done;
  logic                   fn_ok, fid_ok, ridx_ok, stk_full;

  assign accept    = in_valid && !in_stall;
  assign can_load  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    dm1         = depth_r - DP_W'(1);
    dm2         = depth_r - DP_W'(2);
    child_sum   = sat48(stk_q_child, el_r);
    up_path     = (depth_r != '0) ? stk_q_path : '1;
    hash_p      = 32'(key_par_r) + 32'd2;
    hash_f      = {24'd0, fid_r} + 32'd1;
    hash_h      = (hash_p * HASH_MUL_A) ^ (hash_f * HASH_MUL_B);
    slot_empty  = (slot_q_v == '0);
    slot_hit    = !slot_empty && (slot_q_par == key_par_r) && (slot_q_fn == fid_r);
    pe_full     = (pc_r == PC_W'(PATH_ENTRIES));
    last_probe  = (n_r == SL_W'(HASH_SLOTS - 1));
    lookup_done = slot_empty || slot_hit || last_probe;
    fn_ok       = 32'(fn_r) < 32'(FUNCTIONS);
    fid_ok      = 32'(fid_r) < 32'(FUNCTIONS);
    ridx_ok     = 32'(ridx_r) < 32'(pc_r);
    stk_full    = (depth_r == DP_W'(STACK_DEPTH));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (!pt_busy && !ft_busy) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_TOP;
      S_TOP: begin
        if (!enabled_r) begin
          state_nxt = S_DONE;
        end else begin
          case (mode_r)
            MODE_ENTER:   state_nxt = stk_full ? S_DONE : S_HASH;
            MODE_EXIT: begin
              if (depth_r == '0) state_nxt = S_HASH;
              else if (depth_r > DP_W'(1)) state_nxt = S_POP2;
              else state_nxt = S_FN_RD;
            end
            MODE_FOREIGN: state_nxt = S_HASH;
            default:      state_nxt = S_DONE;
          endcase
        end
      end
      S_HASH:  state_nxt = S_PROBE;
      S_PROBE: state_nxt = S_CHECK;
      S_CHECK: begin
        if (lookup_done) state_nxt = (mode_r == MODE_ENTER) ? S_PUSH : S_FN_RD;
        else state_nxt = S_PROBE;
      end
      S_POP2:  state_nxt = S_FN_RD;
      S_PUSH:  state_nxt = S_DONE;
      S_FN_RD: state_nxt = fn_ok ? S_FN_WR : S_PE_RD;
      S_FN_WR: state_nxt = S_PE_RD;
      S_PE_RD: state_nxt = (pi_r >= 0) ? S_PE_WR : S_DONE;
      S_PE_WR: state_nxt = S_DONE;
      S_DONE:  if (can_load) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Memory strobes and handshake outputs.
  always_comb begin
    in_stall   = (state_r != S_IDLE);
    stk_re     = 1'b0;
    stk_ra     = dm1[SD_W-1:0];
    stk_we     = 1'b0;
    stk_wa     = dm1[SD_W-1:0];
    stk_wpath  = stk_q_path;
    stk_wfunc  = stk_q_func;
    stk_wchild = child_sum;
    slot_re    = 1'b0;
    slot_ra    = slot_r;
    slot_we    = 1'b0;
    pe_re      = 1'b0;
    pe_ra      = PE_W'(in_read_index);
    pe_create  = 1'b0;
    pe_wa      = pc_r[PE_W-1:0];
    pe_upd     = '{upd: 1'b0, el: el_r, self_t: self_r};
    fn_re      = 1'b0;
    fn_ra      = FN_W'(in_func_id);
    fn_upd     = '{upd: 1'b0, el: el_r, self_t: self_r};
    case (state_r)
      S_IDLE: begin
        // Fetch the stack top and both read targets up front.
        stk_re = in_valid;
        pe_re  = in_valid;
        fn_re  = in_valid;
      end
      S_TOP: begin
        if (enabled_r && mode_r == MODE_EXIT && depth_r > DP_W'(1)) begin
          stk_re = 1'b1;
          stk_ra = dm2[SD_W-1:0];
        end
        // Charge a foreign call to the enclosing scope's children.
        if (enabled_r && mode_r == MODE_FOREIGN && depth_r != '0) begin
          stk_we = 1'b1;
        end
      end
      S_PROBE: slot_re = 1'b1;
      S_CHECK: begin
        if (slot_empty && !pe_full) begin
          slot_we   = 1'b1;
          pe_create = 1'b1;
        end
      end
      S_POP2: stk_we = 1'b1;
      S_PUSH: begin
        stk_we     = 1'b1;
        stk_wa     = depth_r[SD_W-1:0];
        stk_wpath  = pi_r;
        stk_wfunc  = fid_r;
        stk_wchild = '0;
      end
      S_FN_RD: begin
        fn_re = fn_ok;
        fn_ra = FN_W'(fn_r);
      end
      S_FN_WR: begin
        fn_ra      = FN_W'(fn_r);
        fn_upd.upd = 1'b1;
      end
      S_PE_RD: begin
        pe_re = (pi_r >= 0);
        pe_ra = pi_r[PE_W-1:0];
      end
      S_PE_WR: begin
        pe_wa      = pi_r[PE_W-1:0];
        pe_upd.upd = 1'b1;
      end
      default: ;
    endcase
  end

  // Stack memory.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_path_mem[stk_wa]  <= stk_wpath;
      stk_func_mem[stk_wa]  <= stk_wfunc;
      stk_child_mem[stk_wa] <= stk_wchild;
    end
    if (stk_re) begin
      stk_q_path  <= stk_path_mem[stk_ra];
      stk_q_func  <= stk_func_mem[stk_ra];
      stk_q_child <= stk_child_mem[stk_ra];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      enabled_r   <= 1'b0;
      depth_r     <= '0;
      pc_r        <= '0;
      ovf_r       <= '0;
      drop_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        enabled_r <= cfg_enabled;
      end
      case (state_r)
        S_TOP: begin
          if (enabled_r && mode_r == MODE_ENTER && stk_full) begin
            ovf_r <= inc32(ovf_r);
          end
          if (enabled_r && mode_r == MODE_EXIT && depth_r != '0) begin
            depth_r <= dm1;
          end
        end
        S_CHECK: begin
          if (slot_empty && !pe_full) begin
            pc_r <= pc_r + PC_W'(1);
          end else if ((slot_empty && pe_full) || (!slot_hit && last_probe && !slot_empty)) begin
            drop_r <= inc32(drop_r);
          end
        end
        S_PUSH: depth_r <= depth_r + DP_W'(1);
        default: ;
      endcase
      if (state_r == S_DONE && can_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_r   <= mode_t'(in_mode);
          fid_r    <= in_func_id;
          el_r     <= in_elapsed_ticks;
          ridx_r   <= in_read_index;
          status_r <= enabled_r ? STAT_OK : STAT_DISABLED;
          pi_r     <= '1;
          par_r    <= '1;
          fo_r     <= '0;
          self_r   <= '0;
          calls_r  <= '0;
          tot_r    <= '0;
          stot_r   <= '0;
          min_r    <= '0;
          max_r    <= '0;
        end
      end
      S_TOP: begin
        if (enabled_r) begin
          case (mode_r)
            MODE_ENTER: begin
              if (stk_full) status_r <= STAT_OVERFLOW;
              key_par_r <= up_path;
            end
            MODE_EXIT: begin
              if (depth_r != '0) begin
                // Pop: self is elapsed less child time, never negative.
                fn_r   <= stk_q_func;
                fo_r   <= stk_q_func;
                pi_r   <= stk_q_path;
                self_r <= (stk_q_child >= {16'd0, el_r}) ? 32'd0
                                                         : el_r - stk_q_child[31:0];
              end else begin
                key_par_r <= '1;
                fn_r      <= fid_r;
                fo_r      <= fid_r;
                self_r    <= el_r;
              end
            end
            MODE_FOREIGN: begin
              key_par_r <= up_path;
              par_r     <= up_path;
              fn_r      <= fid_r;
              fo_r      <= fid_r;
              self_r    <= el_r;
            end
            MODE_READ_PATH: begin
              if (ridx_ok) begin
                pi_r    <= PI_W'(ridx_r);
                par_r   <= pe_q_par;
                fo_r    <= pe_q_fn;
                calls_r <= pe_q_stat.calls;
                tot_r   <= pe_q_stat.total;
                stot_r  <= pe_q_stat.self_tot;
              end
            end
            MODE_READ_FUNC: begin
              if (fid_ok) begin
                fo_r    <= fid_r;
                calls_r <= fn_q.calls;
                tot_r   <= fn_q.total;
                stot_r  <= fn_q.self_tot;
                min_r   <= fn_q.min_t;
                max_r   <= fn_q.max_t;
              end
            end
            default: ;
          endcase
        end
      end
      S_HASH: begin
        slot_r <= hash_h[SL_W-1:0];
        n_r    <= '0;
      end
      S_CHECK: begin
        if (slot_empty) begin
          if (pe_full) begin
            pi_r     <= '1;
            status_r <= STAT_FULL;
          end else begin
            pi_r <= PI_W'(pc_r);
          end
        end else if (slot_hit) begin
          pi_r <= PI_W'(slot_q_v - PC_W'(1));
        end else if (last_probe) begin
          pi_r     <= '1;
          status_r <= STAT_FULL;
        end else begin
          slot_r <= slot_r + SL_W'(1);
          n_r    <= n_r + SL_W'(1);
        end
      end
      S_PUSH: begin
        par_r <= key_par_r;
        fo_r  <= fid_r;
      end
      S_PE_WR: begin
        if (mode_r == MODE_EXIT) par_r <= pe_q_par;
      end
      S_DONE: begin
        if (can_load) begin
          o_status_r <= status_r;
          o_pi_r     <= 9'(pi_r);
          o_par_r    <= 9'(par_r);
          o_fo_r     <= fo_r;
          o_self_r   <= self_r;
          o_calls_r  <= calls_r;
          o_tot_r    <= tot_r;
          o_stot_r   <= stot_r;
          o_min_r    <= min_r;
          o_max_r    <= max_r;
        end
      end
      default: ;
    endcase
  end

  cpprof_path_tab #(
    .PATH_ENTRIES(PATH_ENTRIES),
    .HASH_SLOTS  (HASH_SLOTS)
  ) u_path_tab (
    .clk       (clk),
    .rst_n     (rst_n),
    .busy      (pt_busy),
    .slot_re   (slot_re),
    .slot_ra   (slot_ra),
    .slot_q_v  (slot_q_v),
    .slot_q_par(slot_q_par),
    .slot_q_fn (slot_q_fn),
    .slot_we   (slot_we),
    .slot_wa   (slot_r),
    .slot_wv   (pc_r + PC_W'(1)),
    .slot_wpar (key_par_r),
    .slot_wfn  (fid_r),
    .pe_re     (pe_re),
    .pe_ra     (pe_ra),
    .pe_q_par  (pe_q_par),
    .pe_q_fn   (pe_q_fn),
    .pe_q_stat (pe_q_stat),
    .pe_create (pe_create),
    .pe_upd    (pe_upd),
    .pe_wa     (pe_wa),
    .pe_wpar   (key_par_r),
    .pe_wfn    (fid_r)
  );

  cpprof_func_tab #(
    .FUNCTIONS(FUNCTIONS)
  ) u_func_tab (
    .clk     (clk),
    .rst_n   (rst_n),
    .busy    (ft_busy),
    .rd_en   (fn_re),
    .rd_addr (fn_ra),
    .rd_q    (fn_q),
    .upd     (fn_upd),
    .upd_addr(fn_ra)
  );

  assign out_valid            = out_valid_r;
  assign out_status           = o_status_r;
  assign out_path_index       = o_pi_r;
  assign out_parent_index     = o_par_r;
  assign out_func_out         = o_fo_r;
  assign out_self_ticks       = o_self_r;
  assign out_call_count       = o_calls_r;
  assign out_total_ticks      = o_tot_r;
  assign out_self_total_ticks = o_stot_r;
  assign out_min_ticks        = o_min_r;
  assign out_max_ticks        = o_max_r;

endmodule

// ----- rtl/cpprof_checker.sv -----
// Port-level checker for the call-path profiler and its bind.
module cpprof_checker import cpprof_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_status,
  input logic signed [8:0] out_path_index,
  input logic [31:0]       out_call_count,
  input logic [31:0]       out_min_ticks,
  input logic [31:0]       out_max_ticks
);

  // Hold a stalled word.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_path_index) && $stable(out_status))
    else $error("stalled result word changed");

  a_no_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_DISABLED || out_status == STAT_OVERFLOW ||
                  out_status == STAT_FULL) |-> out_path_index == -9'sd1)
    else $error("path index set on a failed word");

  a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_DISABLED |-> out_call_count == 32'd0)
    else $error("disabled word carries statistics");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_ticks <= out_max_ticks)
    else $error("minimum above maximum");

endmodule

bind call_path_profiler_unit cpprof_checker u_cpprof_checker (.*);
